FILE: rtl/tts_pkg.sv
// Shared types and constants of the task table scheduler.
// Used by tts_ctrl, tts_dp and task_table_scheduler; depends on nothing.
package tts_pkg;

    localparam int MAX_TASKS = 256;
    localparam int IDX_W     = 8;
    localparam int CNT_W     = 9;
    localparam int WAIT_W    = 9;
    localparam int PRIO_W    = 8;

    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_FORK,
        CMD_EXIT,
        CMD_WAIT
    } t_cmd;

    typedef enum logic [1:0] {
        TS_READY,
        TS_RUNNING,
        TS_BLOCKED,
        TS_TERM
    } t_tstate;

    typedef enum logic [2:0] {
        RS_OK,
        RS_FULL,
        RS_NONE_READY,
        RS_NOT_NEEDED,
        RS_BAD
    } t_status;

    typedef struct packed {
        t_tstate             state;
        logic [PRIO_W-1:0]   prio;
        logic [IDX_W-1:0]    parent;
        logic [WAIT_W-1:0]   wcount;
        logic                waited;
    } t_entry;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_FORK,
        OP_RD_CUR,
        OP_RD_TGT,
        OP_WR_TERM,
        OP_WR_PAR,
        OP_WR_TGT,
        OP_WR_BLK,
        OP_WR_DEMOTE,
        OP_WR_PICK,
        OP_SCAN_INIT,
        OP_SCAN
    } t_op;

    typedef enum logic [1:0] {
        ID_CUR,
        ID_NEW,
        ID_PICK
    } t_idsel;

    typedef struct packed {
        logic    load;
        t_op     op;
        logic    res_en;
        t_status res_status;
        t_idsel  res_id;
        logic    set_cur;
        logic    push;
    } t_ctl;

    typedef struct packed {
        t_cmd              cmd;
        logic              count_zero;
        logic              full;
        logic              has_cur;
        logic              tgt_bad;
        logic              tgt_self;
        t_tstate           rd_state;
        logic              rd_waited;
        logic              par_ok;
        logic              scan_done;
        logic              found;
        logic              mode;
        logic              out_free;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  cur;
    } t_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_DEMOTE,
        S_PICK,
        S_EXIT_WR,
        S_PAR_CHK,
        S_TGT_CHK,
        S_WAIT_WR,
        S_RESULT
    } t_state;

endpackage

FILE: rtl/tts_ctrl.sv
// Sequencer of the task table scheduler: steps each request through its table accesses.
// Depends on tts_pkg; drives the datapath tts_dp through t_ctl and reads t_sts.
module tts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  tts_pkg::t_sts i_sts,
    output tts_pkg::t_ctl o_ctl
);
    import tts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_TICK: n_state = i_sts.count_zero ? S_RESULT : S_SCAN;
                    CMD_FORK: n_state = S_RESULT;
                    CMD_EXIT: n_state = i_sts.has_cur ? S_EXIT_WR : S_RESULT;
                    CMD_WAIT: begin
                        if (!i_sts.has_cur || i_sts.tgt_bad || i_sts.tgt_self) begin
                            n_state = S_RESULT;
                        end else begin
                            n_state = S_TGT_CHK;
                        end
                    end
                    default: n_state = S_RESULT;
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    if (!i_sts.found || !i_sts.mode) begin
                        n_state = S_RESULT;
                    end else if (i_sts.has_cur) begin
                        n_state = S_DEMOTE;
                    end else begin
                        n_state = S_PICK;
                    end
                end
            end
            S_DEMOTE:  n_state = S_PICK;
            S_PICK:    n_state = S_RESULT;
            S_EXIT_WR: n_state = i_sts.rd_waited ? S_PAR_CHK : S_RESULT;
            S_PAR_CHK: n_state = S_RESULT;
            S_TGT_CHK: n_state = (i_sts.rd_state == TS_TERM) ? S_RESULT : S_WAIT_WR;
            S_WAIT_WR: n_state = S_RESULT;
            S_RESULT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl            = '0;
        o_ctl.op         = OP_NOP;
        o_ctl.res_status = RS_OK;
        o_ctl.res_id     = ID_CUR;
        o_stall          = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                o_ctl.load = i_valid;
            end
            S_DECODE: begin
                unique case (i_sts.cmd)
                    CMD_TICK: begin
                        if (i_sts.count_zero) begin
                            o_ctl.res_en     = 1'b1;
                            o_ctl.res_status = RS_NONE_READY;
                        end else begin
                            o_ctl.op = OP_SCAN_INIT;
                        end
                    end
                    CMD_FORK: begin
                        o_ctl.res_en = 1'b1;
                        if (i_sts.full) begin
                            o_ctl.res_status = RS_FULL;
                        end else begin
                            o_ctl.op     = OP_FORK;
                            o_ctl.res_id = ID_NEW;
                        end
                    end
                    CMD_EXIT: begin
                        if (i_sts.has_cur) begin
                            o_ctl.op = OP_RD_CUR;
                        end else begin
                            o_ctl.res_en     = 1'b1;
                            o_ctl.res_status = RS_BAD;
                        end
                    end
                    CMD_WAIT: begin
                        if (!i_sts.has_cur || i_sts.tgt_bad) begin
                            o_ctl.res_en     = 1'b1;
                            o_ctl.res_status = RS_BAD;
                        end else if (i_sts.tgt_self) begin
                            o_ctl.res_en     = 1'b1;
                            o_ctl.res_status = RS_NOT_NEEDED;
                        end else begin
                            o_ctl.op = OP_RD_TGT;
                        end
                    end
                    default: o_ctl.op = OP_NOP;
                endcase
            end
            S_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_ctl.op = OP_SCAN;
                end else if (!i_sts.found) begin
                    o_ctl.res_en     = 1'b1;
                    o_ctl.res_status = RS_NONE_READY;
                end else if (!i_sts.mode) begin
                    o_ctl.res_en  = 1'b1;
                    o_ctl.res_id  = ID_PICK;
                    o_ctl.set_cur = 1'b1;
                end else if (i_sts.has_cur) begin
                    o_ctl.op = OP_RD_CUR;
                end
            end
            S_DEMOTE: begin
                if (i_sts.rd_state == TS_RUNNING) begin
                    o_ctl.op = OP_WR_DEMOTE;
                end
            end
            S_PICK: begin
                o_ctl.op      = OP_WR_PICK;
                o_ctl.res_en  = 1'b1;
                o_ctl.res_id  = ID_PICK;
                o_ctl.set_cur = 1'b1;
            end
            S_EXIT_WR: begin
                o_ctl.op     = OP_WR_TERM;
                o_ctl.res_en = !i_sts.rd_waited;
            end
            S_PAR_CHK: begin
                if (i_sts.par_ok && (i_sts.rd_state == TS_BLOCKED)) begin
                    o_ctl.op = OP_WR_PAR;
                end
                o_ctl.res_en = 1'b1;
            end
            S_TGT_CHK: begin
                if (i_sts.rd_state == TS_TERM) begin
                    o_ctl.res_en     = 1'b1;
                    o_ctl.res_status = RS_NOT_NEEDED;
                end else begin
                    o_ctl.op = OP_WR_TGT;
                end
            end
            S_WAIT_WR: begin
                o_ctl.op     = OP_WR_BLK;
                o_ctl.res_en = 1'b1;
            end
            S_RESULT: begin
                o_ctl.push = i_sts.out_free;
            end
            default: o_ctl.op = OP_NOP;
        endcase
    end

endmodule

FILE: rtl/tts_dp.sv
// Datapath of the task table scheduler: task table memory, scan unit, scheduler
// registers and output register. Depends on tts_pkg; commanded by tts_ctrl.
module tts_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tts_pkg::t_ctl                 i_ctl,
    output tts_pkg::t_sts                 o_sts,
    input  logic [1:0]                    i_command,
    input  logic [tts_pkg::IDX_W-1:0]     i_target_pid,
    input  logic [tts_pkg::PRIO_W-1:0]    i_new_priority,
    input  logic                          i_new_blocked,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [tts_pkg::IDX_W-1:0]     o_task_id,
    output logic                          o_current_valid
);
    import tts_pkg::*;

    t_entry r_mem [MAX_TASKS];
    t_entry r_rd_word;

    t_cmd               r_cmd;
    logic [IDX_W-1:0]   r_tgt;
    logic [PRIO_W-1:0]  r_prio;
    logic               r_blk;
    logic               r_mode;
    logic [CNT_W-1:0]   r_count;
    logic [IDX_W-1:0]   r_cur;
    logic               r_has;
    logic [IDX_W-1:0]   r_par;

    logic [IDX_W-1:0]   r_scan_idx;
    logic [CNT_W-1:0]   r_left;
    logic               r_ev_v;
    logic [IDX_W-1:0]   r_ev_idx;
    logic               r_found;
    logic [IDX_W-1:0]   r_pick;
    logic [PRIO_W-1:0]  r_best;
    t_entry             r_pick_word;

    t_status            r_res_status;
    logic [IDX_W-1:0]   r_res_id;
    logic               r_out_valid;
    t_status            r_out_status;
    logic [IDX_W-1:0]   r_out_id;
    logic               r_out_cur;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_entry             wr_data;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               scan_issue;
    logic [CNT_W-1:0]   scan_next;
    logic [CNT_W-1:0]   cur_next;
    logic               out_free;

    assign scan_issue = (r_left != '0) && !(r_found && !r_mode);
    assign scan_next  = {1'b0, r_scan_idx} + CNT_W'(1);
    assign cur_next   = {1'b0, r_cur} + CNT_W'(1);
    assign out_free   = !r_out_valid || !i_stall;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_cur;
        wr_data = r_rd_word;
        rd_en   = 1'b0;
        rd_addr = r_cur;
        case (i_ctl.op)
            OP_FORK: begin
                wr_en          = 1'b1;
                wr_addr        = r_count[IDX_W-1:0];
                wr_data.state  = r_blk ? TS_BLOCKED : TS_READY;
                wr_data.prio   = r_prio;
                wr_data.parent = r_has ? r_cur : r_count[IDX_W-1:0];
                wr_data.wcount = '0;
                wr_data.waited = 1'b0;
            end
            OP_RD_CUR: begin
                rd_en = 1'b1;
            end
            OP_RD_TGT: begin
                rd_en   = 1'b1;
                rd_addr = r_tgt;
            end
            OP_WR_TERM: begin
                wr_en         = 1'b1;
                wr_data.state = TS_TERM;
                rd_en         = 1'b1;
                rd_addr       = r_rd_word.parent;
            end
            OP_WR_PAR: begin
                wr_en   = 1'b1;
                wr_addr = r_par;
                if (r_rd_word.wcount != '0) begin
                    wr_data.wcount = r_rd_word.wcount - WAIT_W'(1);
                end
                if (r_rd_word.wcount <= WAIT_W'(1)) begin
                    wr_data.state = TS_READY;
                end
            end
            OP_WR_TGT: begin
                wr_en          = 1'b1;
                wr_addr        = r_tgt;
                wr_data.waited = 1'b1;
                rd_en          = 1'b1;
            end
            OP_WR_BLK: begin
                wr_en         = 1'b1;
                wr_data.state = TS_BLOCKED;
                if (r_rd_word.wcount != WAIT_MAX) begin
                    wr_data.wcount = r_rd_word.wcount + WAIT_W'(1);
                end
            end
            OP_WR_DEMOTE: begin
                wr_en         = 1'b1;
                wr_data.state = TS_READY;
            end
            OP_WR_PICK: begin
                wr_en         = 1'b1;
                wr_addr       = r_pick;
                wr_data       = r_pick_word;
                wr_data.state = TS_RUNNING;
            end
            OP_SCAN: begin
                rd_en   = scan_issue;
                rd_addr = r_scan_idx;
            end
            default: wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_word <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= t_cmd'(i_command);
            r_tgt  <= i_target_pid;
            r_prio <= i_new_priority;
            r_blk  <= i_new_blocked;
        end
        if (i_ctl.op == OP_WR_TERM) begin
            r_par <= r_rd_word.parent;
        end
        if (i_ctl.res_en) begin
            r_res_status <= i_ctl.res_status;
            case (i_ctl.res_id)
                ID_NEW:  r_res_id <= r_count[IDX_W-1:0];
                ID_PICK: r_res_id <= r_pick;
                default: r_res_id <= r_cur;
            endcase
        end
        if (i_ctl.push) begin
            r_out_status <= r_res_status;
            r_out_id     <= r_res_id;
            r_out_cur    <= r_has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= 1'b0;
            r_count     <= '0;
            r_cur       <= '0;
            r_has       <= 1'b0;
            r_out_valid <= 1'b0;
            r_ev_v      <= 1'b0;
            r_found     <= 1'b0;
            r_left      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (i_ctl.op == OP_FORK) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (i_ctl.set_cur) begin
                r_cur <= r_pick;
                r_has <= 1'b1;
            end
            if (i_ctl.push) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_ctl.op == OP_SCAN_INIT) begin
                r_found <= 1'b0;
                r_ev_v  <= 1'b0;
                r_left  <= r_count;
            end else if (i_ctl.op == OP_SCAN) begin
                r_ev_v <= scan_issue;
                if (scan_issue) begin
                    r_left <= r_left - CNT_W'(1);
                end
                if (r_ev_v) begin
                    if (!r_mode) begin
                        if (!r_found && (r_rd_word.state == TS_READY)) begin
                            r_found <= 1'b1;
                        end
                    end else if ((r_rd_word.state == TS_READY ||
                                  r_rd_word.state == TS_RUNNING) &&
                                 (!r_found || (r_rd_word.prio > r_best))) begin
                        r_found <= 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_SCAN_INIT) begin
            if (r_mode || !r_has || (cur_next == r_count)) begin
                r_scan_idx <= '0;
            end else begin
                r_scan_idx <= cur_next[IDX_W-1:0];
            end
        end else if ((i_ctl.op == OP_SCAN) && scan_issue) begin
            r_scan_idx <= (scan_next == r_count) ? '0 : scan_next[IDX_W-1:0];
        end
        if (i_ctl.op == OP_SCAN) begin
            r_ev_idx <= r_scan_idx;
            if (r_ev_v) begin
                if (!r_mode) begin
                    if (!r_found && (r_rd_word.state == TS_READY)) begin
                        r_pick <= r_ev_idx;
                    end
                end else if ((r_rd_word.state == TS_READY ||
                              r_rd_word.state == TS_RUNNING) &&
                             (!r_found || (r_rd_word.prio > r_best))) begin
                    r_pick      <= r_ev_idx;
                    r_best      <= r_rd_word.prio;
                    r_pick_word <= r_rd_word;
                end
            end
        end
    end

    always_comb begin
        o_sts.cmd        = r_cmd;
        o_sts.count_zero = (r_count == '0);
        o_sts.full       = (r_count == CNT_W'(MAX_TASKS));
        o_sts.has_cur    = r_has;
        o_sts.tgt_bad    = ({1'b0, r_tgt} >= r_count);
        o_sts.tgt_self   = (r_tgt == r_cur);
        o_sts.rd_state   = r_rd_word.state;
        o_sts.rd_waited  = r_rd_word.waited;
        o_sts.par_ok     = ({1'b0, r_par} < r_count) && (r_par != r_cur);
        o_sts.scan_done  = (r_found && !r_mode) || ((r_left == '0) && !r_ev_v);
        o_sts.found      = r_found;
        o_sts.mode       = r_mode;
        o_sts.out_free   = out_free;
        o_sts.count      = r_count;
        o_sts.cur        = r_cur;
    end

    assign o_valid         = r_out_valid;
    assign o_status        = r_out_status;
    assign o_task_id       = r_out_id;
    assign o_current_valid = r_out_cur;

endmodule

FILE: rtl/task_table_scheduler.sv
// Task table scheduler: a table of up to 256 tasks taking tick, fork, exit and wait requests,
// scheduling round robin or highest priority first. A tick on a non-empty table reads the table
// one entry per cycle through the single read port of the task memory. A round-robin tick stops
// at the first ready task; a priority tick reads every task in the table.
// One request is worked on at a time; the finished result waits in an output register, so
// the next request is taken while it is still unclaimed. Depends on tts_pkg, tts_ctrl, tts_dp.
module task_table_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [1:0]                    i_command,
    input  logic [tts_pkg::IDX_W-1:0]     i_target_pid,
    input  logic [tts_pkg::PRIO_W-1:0]    i_new_priority,
    input  logic                          i_new_blocked,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [2:0]                    o_status,
    output logic [tts_pkg::IDX_W-1:0]     o_task_id,
    output logic                          o_current_valid,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data
);
    import tts_pkg::*;

    t_ctl s_ctl;
    t_sts s_sts;

    tts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (s_sts),
        .o_ctl   (s_ctl)
    );

    tts_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (s_ctl),
        .o_sts           (s_sts),
        .i_command       (i_command),
        .i_target_pid    (i_target_pid),
        .i_new_priority  (i_new_priority),
        .i_new_blocked   (i_new_blocked),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_status        (o_status),
        .o_task_id       (o_task_id),
        .o_current_valid (o_current_valid)
    );

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sts.count <= CNT_W'(MAX_TASKS))
        else $error("Task count exceeds the table size.");

    a_cur_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_sts.has_cur |-> ({1'b0, s_sts.cur} < s_sts.count))
        else $error("Current task lies outside the table.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("A request was taken while another was in progress.");
`endif

endmodule

FILE: tb/sv/tb.sv
// Testbench for task_table_scheduler: directed table of requests, then random request streams,
// each result checked against a behavioural task table kept in this file.
// Depends on tts_pkg and the task_table_scheduler RTL.
`timescale 1ns / 100ps

module tb;
    import tts_pkg::*;

    typedef struct packed {
        t_cmd       cmd;
        logic [7:0] tgt;
        logic [7:0] prio;
        logic       blk;
    } t_req;

    typedef struct packed {
        t_status    status;
        logic [7:0] id;
        logic       cv;
    } t_res;

    typedef struct {
        t_req req;
        logic chk;
        t_res res;
    } t_row;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_valid = 0;
    logic       o_stall;
    logic [1:0] i_command = '0;
    logic [7:0] i_target_pid = '0;
    logic [7:0] i_new_priority = '0;
    logic       i_new_blocked = 0;
    logic       o_valid;
    logic       i_stall = 0;
    logic [2:0] o_status;
    logic [7:0] o_task_id;
    logic       o_current_valid;
    logic       i_cfg_wr_en = 0;
    logic       i_cfg_wr_data = 0;

    task_table_scheduler dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Behavioural copy of the scheduler state.
    t_tstate    tab_state [MAX_TASKS];
    logic [7:0] tab_prio  [MAX_TASKS];
    int         tab_par   [MAX_TASKS];
    int         tab_wcnt  [MAX_TASKS];
    logic       tab_waited[MAX_TASKS];
    int         n_tasks;
    int         cur_idx;
    logic       cur_ok;
    logic       mode;

    t_res sched_expected[$];
    t_res typed_expected[$];
    logic typed_flag[$];
    int   n_fail = 0;
    int   n_acc = 0;
    int   n_res = 0;
    int   idle_cycles = 0;

    function automatic t_res sched_step(t_req r);
        t_res o;
        int   idx;
        int   pick;
        logic found;
        int   p;
        found = 0;
        pick = 0;
        o.status = RS_OK;
        o.id = cur_idx[7:0];
        case (r.cmd)
            CMD_TICK: begin
                if (n_tasks == 0) begin
                    o.status = RS_NONE_READY;
                end else if (!mode) begin
                    idx = cur_ok ? cur_idx % n_tasks : n_tasks - 1;
                    for (int i = 0; i < n_tasks && !found; i++) begin
                        idx = (idx + 1) % n_tasks;
                        if (tab_state[idx] == TS_READY) begin
                            pick = idx;
                            found = 1;
                        end
                    end
                end else begin
                    for (int i = 0; i < n_tasks; i++) begin
                        if (tab_state[i] inside {TS_READY, TS_RUNNING} &&
                            (!found || tab_prio[i] > tab_prio[pick])) begin
                            pick = i;
                            found = 1;
                        end
                    end
                    if (found) begin
                        if (cur_ok && cur_idx < n_tasks && tab_state[cur_idx] == TS_RUNNING)
                            tab_state[cur_idx] = TS_READY;
                        tab_state[pick] = TS_RUNNING;
                    end
                end
                if (n_tasks != 0 && !found) begin
                    o.status = RS_NONE_READY;
                end else if (found) begin
                    cur_idx = pick;
                    cur_ok = 1;
                    o.id = pick[7:0];
                end
            end
            CMD_FORK: begin
                if (n_tasks >= MAX_TASKS) begin
                    o.status = RS_FULL;
                end else begin
                    tab_state[n_tasks] = r.blk ? TS_BLOCKED : TS_READY;
                    tab_prio[n_tasks] = r.prio;
                    tab_par[n_tasks] = cur_ok ? cur_idx : n_tasks;
                    tab_wcnt[n_tasks] = 0;
                    tab_waited[n_tasks] = 0;
                    o.id = n_tasks[7:0];
                    n_tasks++;
                end
            end
            CMD_EXIT: begin
                if (!cur_ok || cur_idx >= n_tasks) begin
                    o.status = RS_BAD;
                end else begin
                    tab_state[cur_idx] = TS_TERM;
                    if (tab_waited[cur_idx]) begin
                        p = tab_par[cur_idx];
                        if (p < n_tasks && tab_state[p] == TS_BLOCKED) begin
                            if (tab_wcnt[p] <= 1) tab_state[p] = TS_READY;
                            if (tab_wcnt[p] > 0) tab_wcnt[p]--;
                        end
                    end
                end
            end
            default: begin
                if (!cur_ok || cur_idx >= n_tasks || r.tgt >= n_tasks) begin
                    o.status = RS_BAD;
                end else if (tab_state[r.tgt] == TS_TERM || r.tgt == cur_idx) begin
                    o.status = RS_NOT_NEEDED;
                end else begin
                    tab_waited[r.tgt] = 1;
                    tab_state[cur_idx] = TS_BLOCKED;
                    if (tab_wcnt[cur_idx] < 511) tab_wcnt[cur_idx]++;
                end
            end
        endcase
        o.cv = cur_ok;
        return o;
    endfunction

    // Sender: bursts and gaps; each request goes through the predictor on acceptance.
    task automatic send(t_req r, logic chk, t_res typed);
        int gap;
        gap = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_command <= r.cmd;
        i_target_pid <= r.tgt;
        i_new_priority <= r.prio;
        i_new_blocked <= r.blk;
        do @(posedge i_clk); while (o_stall);
        sched_expected.push_back(sched_step(r));
        typed_flag.push_back(chk);
        typed_expected.push_back(typed);
    endtask

    task automatic drain_and_set(logic m);
        i_valid <= 0;
        while (sched_expected.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_wr_en <= 1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en <= 0;
        mode = m;
    endtask

    task automatic random_req(int heavy);
        t_req r;
        int   k;
        k = $urandom_range(0, 99);
        r.tgt = (n_tasks > 0 && $urandom_range(0, 3) != 0) ?
                8'($urandom_range(0, n_tasks - 1)) : 8'($urandom);
        r.prio = 8'($urandom);
        r.blk = $urandom_range(0, 3) == 0;
        if (k < 40 - heavy) r.cmd = CMD_TICK;
        else if (k < 60) r.cmd = CMD_FORK;
        else if (k < 80) r.cmd = CMD_EXIT;
        else r.cmd = CMD_WAIT;
        send(r, 0, '0);
    endtask

    // Receiver stall pattern and result checking.
    always @(posedge i_clk) begin
        t_res exp_r;
        t_res typ;
        logic flag;
        if (!i_rst_n) begin
            i_stall <= 0;
        end else begin
            i_stall <= (n_acc % 300 < 150) ? 0 : ($urandom_range(0, 2) == 0);
            if (o_valid && !i_stall) begin
                n_res++;
                if (sched_expected.size() == 0) begin
                    $error("unexpected result status=%0d id=%0d", o_status, o_task_id);
                    n_fail++;
                end else begin
                    exp_r = sched_expected.pop_front();
                    typ = typed_expected.pop_front();
                    flag = typed_flag.pop_front();
                    if (flag && typ != exp_r) begin
                        $error("table row disagrees with prediction: %p vs %p", typ, exp_r);
                        n_fail++;
                    end
                    if (o_status !== exp_r.status) begin
                        $error("status expected %0d actual %0d", exp_r.status, o_status);
                        n_fail++;
                    end
                    if (o_task_id !== exp_r.id) begin
                        $error("task_id expected %0d actual %0d", exp_r.id, o_task_id);
                        n_fail++;
                    end
                    if (o_current_valid !== exp_r.cv) begin
                        $error("current_valid expected %0d actual %0d", exp_r.cv,
                               o_current_valid);
                        n_fail++;
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
            if (i_valid && !o_stall) n_acc <= n_acc + 1;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > 5000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    t_row rows[$];

    function automatic t_row mk(t_cmd c, int tg, int pr, int bl, logic chk,
                                t_status st, int id, int cv);
        t_row w;
        w.req = '{c, 8'(tg), 8'(pr), 1'(bl)};
        w.chk = chk;
        w.res = '{st, 8'(id), 1'(cv)};
        return w;
    endfunction

    initial begin
        n_tasks = 0;
        cur_idx = 0;
        cur_ok = 0;
        mode = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        rows.push_back(mk(CMD_TICK, 0, 0, 0, 1, RS_NONE_READY, 0, 0));
        rows.push_back(mk(CMD_EXIT, 0, 0, 0, 1, RS_BAD, 0, 0));
        rows.push_back(mk(CMD_WAIT, 255, 0, 0, 1, RS_BAD, 0, 0));
        rows.push_back(mk(CMD_FORK, 0, 255, 0, 1, RS_OK, 0, 0));
        rows.push_back(mk(CMD_FORK, 0, 0, 1, 1, RS_OK, 1, 0));
        rows.push_back(mk(CMD_FORK, 0, 128, 0, 1, RS_OK, 2, 0));
        rows.push_back(mk(CMD_TICK, 0, 0, 0, 1, RS_OK, 0, 1));
        rows.push_back(mk(CMD_WAIT, 0, 0, 0, 1, RS_NOT_NEEDED, 0, 1));
        rows.push_back(mk(CMD_WAIT, 200, 0, 0, 1, RS_BAD, 0, 1));
        rows.push_back(mk(CMD_FORK, 0, 7, 0, 1, RS_OK, 3, 1));
        rows.push_back(mk(CMD_WAIT, 3, 0, 0, 0, RS_OK, 0, 0));
        rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, RS_OK, 0, 0));
        rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, RS_OK, 0, 0));
        rows.push_back(mk(CMD_EXIT, 0, 0, 0, 0, RS_OK, 0, 0));
        rows.push_back(mk(CMD_WAIT, 3, 0, 0, 0, RS_OK, 0, 0));
        rows.push_back(mk(CMD_TICK, 0, 0, 0, 0, RS_OK, 0, 0));
        foreach (rows[i]) send(rows[i].req, rows[i].chk, rows[i].res);

        drain_and_set(1);
        for (int i = 0; i < 8; i++) random_req(0);
        for (int i = 0; i < 300; i++) random_req(0);

        // Fill the table to the top so that a fork reports a full table.
        drain_and_set(0);
        while (n_tasks < MAX_TASKS) send('{CMD_FORK, 8'd0, 8'($urandom), 1'($urandom)}, 0, '0);
        send('{CMD_FORK, 8'd255, 8'd255, 1'b1}, 0, '0);
        for (int i = 0; i < 400; i++) random_req(20);
        drain_and_set(1);
        for (int i = 0; i < 400; i++) random_req(20);

        // Fresh table contents cannot be had without reset, so the rest stays on this table.
        drain_and_set(0);
        for (int i = 0; i < 220; i++) random_req(10);
        drain_and_set(1);
        for (int i = 0; i < 220; i++) random_req(10);

        i_valid <= 0;
        while (sched_expected.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Ran %0d requests and checked %0d results in both scheduling modes,",
                 n_acc, n_res);
        $display("including an empty table, a full table and requests without a current task.");
        if (n_fail == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
